// File: src/lps_pkg.sv
package lps_pkg;

    localparam int HITS_W  = 6;
    localparam int POS_W   = 3;
    localparam int GAIN_W  = 16;
    localparam int BASE_W  = 10;
    localparam int OLIM_W  = 8;
    localparam int ILIM_W  = 7;
    localparam int IWIN_W  = 8;
    localparam int ISUM_W  = 8;
    localparam int ERR_W   = 4;
    localparam int DERR_W  = 5;
    localparam int MULB_W  = 9;
    localparam int PROD_W  = GAIN_W + MULB_W;
    localparam int ACC_W   = 26;
    localparam int DRIVE_W = 20;
    localparam int CORR_W  = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INT_WIN  = 3'd7;

    localparam logic [GAIN_W-1:0] RST_GAIN_P  = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_I  = 16'd512;
    localparam logic [GAIN_W-1:0] RST_GAIN_D  = 16'd26;
    localparam logic [POS_W-1:0]  RST_TARGET  = 3'd3;
    localparam logic [BASE_W-1:0] RST_BASE    = 10'd300;
    localparam logic [OLIM_W-1:0] RST_OUT_LIM = 8'd120;
    localparam logic [ILIM_W-1:0] RST_INT_LIM = 7'd50;
    localparam logic [IWIN_W-1:0] RST_INT_WIN = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     step_pos;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // truncated mean of set-bit weights (bit i weighs i+1); 0 when empty
    function automatic logic [POS_W-1:0] line_pos(input logic [HITS_W-1:0] hits);
        logic [2:0]       cnt;
        logic [4:0]       wsum;
        logic [POS_W-1:0] pos;
        logic [5:0]       prod;
        cnt  = '0;
        wsum = '0;
        pos  = '0;
        for (int i = 0; i < HITS_W; i++) begin
            if (hits[i]) begin
                cnt  = cnt + 3'd1;
                wsum = wsum + 5'(i + 1);
            end
        end
        if (cnt != 3'd0) begin
            for (int p = 1; p <= HITS_W; p++) begin
                prod = 6'(p) * {3'b0, cnt};
                if (prod <= {1'b0, wsum})
                    pos = POS_W'(p);
            end
        end
        return pos;
    endfunction

endpackage

// File: src/lps_in_if.sv
interface lps_in_if;
    logic                          valid;
    logic                          ready;
    logic [lps_pkg::HITS_W-1:0]    line_hits;

    modport source (output valid, output line_hits, input ready);
    modport sink   (input valid, input line_hits, output ready);
endinterface

// File: src/lps_out_if.sv
interface lps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lps_pkg::DRIVE_W-1:0]  drive_left;
    logic signed [lps_pkg::DRIVE_W-1:0]  drive_right;
    logic signed [lps_pkg::CORR_W-1:0]   correction;
    logic [lps_pkg::POS_W-1:0]           line_position;

    modport source (output valid, output drive_left, output drive_right,
                    output correction, output line_position, input ready);
    modport sink   (input valid, input drive_left, input drive_right,
                    input correction, input line_position, output ready);
endinterface

// File: src/lps_ctrl.sv
module lps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lps_pkg::t_stat i_stat,
    output lps_pkg::t_cmd  o_cmd
);
    import lps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_P;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_POS;
                end
            end
            ST_POS: begin
                o_cmd.step_pos = 1'b1;
                n_state        = ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state       = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_I;
                o_cmd.acc_en  = 1'b1;
                n_state       = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                o_cmd.acc_en  = 1'b1;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: src/lps_dp.sv
module lps_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  lps_pkg::t_cmd                        i_cmd,
    output lps_pkg::t_stat                       o_stat,
    input  logic [lps_pkg::HITS_W-1:0]           i_line_hits,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lps_pkg::DRIVE_W-1:0]   o_drive_left,
    output logic signed [lps_pkg::DRIVE_W-1:0]   o_drive_right,
    output logic signed [lps_pkg::CORR_W-1:0]    o_correction,
    output logic [lps_pkg::POS_W-1:0]            o_line_position
);
    import lps_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [POS_W-1:0]         r_target;
    logic [BASE_W-1:0]        r_base;
    logic [OLIM_W-1:0]        r_olim;
    logic [ILIM_W-1:0]        r_ilim;
    logic [IWIN_W-1:0]        r_iwin;

    // loop state
    logic signed [ISUM_W-1:0] r_isum;
    logic signed [ERR_W-1:0]  r_perr;
    logic [POS_W-1:0]         r_held;

    // per-word working registers
    logic [HITS_W-1:0]        r_hits;
    logic [POS_W-1:0]         r_pos;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DERR_W-1:0] r_derr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive_left, r_drive_right;
    logic signed [CORR_W-1:0]  r_corr;
    logic [POS_W-1:0]          r_out_pos;

    logic [POS_W-1:0]          hits_pos;
    logic [POS_W-1:0]          n_pos;
    logic signed [ERR_W:0]     err_wide;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [9:0]         err10;
    logic signed [9:0]         win10;
    logic                      in_window;
    logic signed [ISUM_W:0]    sum9;
    logic signed [ISUM_W:0]    lim9;
    logic signed [ISUM_W-1:0]  n_isum;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   bound;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [DRIVE_W-1:0] base20;
    logic signed [DRIVE_W-1:0] corr20;
    logic signed [DRIVE_W-1:0] n_left, n_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= RST_GAIN_P;
            r_gain_i <= RST_GAIN_I;
            r_gain_d <= RST_GAIN_D;
            r_target <= RST_TARGET;
            r_base   <= RST_BASE;
            r_olim   <= RST_OUT_LIM;
            r_ilim   <= RST_INT_LIM;
            r_iwin   <= RST_INT_WIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P:  r_gain_p <= i_cfg_data;
                REG_GAIN_I:  r_gain_i <= i_cfg_data;
                REG_GAIN_D:  r_gain_d <= i_cfg_data;
                REG_TARGET:  r_target <= i_cfg_data[POS_W-1:0];
                REG_BASE:    r_base   <= i_cfg_data[BASE_W-1:0];
                REG_OUT_LIM: r_olim   <= i_cfg_data[OLIM_W-1:0];
                REG_INT_LIM: r_ilim   <= i_cfg_data[ILIM_W-1:0];
                REG_INT_WIN: r_iwin   <= i_cfg_data[IWIN_W-1:0];
            endcase
        end
    end

    // position, error and integral update
    always_comb begin
        hits_pos  = line_pos(r_hits);
        n_pos     = (hits_pos != '0) ? hits_pos : r_held;
        err_wide  = $signed({2'b00, r_target}) - $signed({2'b00, n_pos});
        n_err     = err_wide[ERR_W-1:0];
        err10     = {{(10-ERR_W){n_err[ERR_W-1]}}, n_err};
        win10     = $signed({2'b00, r_iwin});
        in_window = (err10 > -win10) && (err10 < win10);
        sum9      = {r_isum[ISUM_W-1], r_isum} + {{(ISUM_W+1-ERR_W){n_err[ERR_W-1]}}, n_err};
        lim9      = $signed({2'b00, r_ilim});
        if (sum9 < -lim9)
            sum9 = -lim9;
        if (sum9 > lim9)
            sum9 = lim9;
        n_isum    = in_window ? sum9[ISUM_W-1:0] : r_isum;
    end

    // shared gain multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_I: begin
                mul_a = r_gain_i;
                mul_b = {r_isum[ISUM_W-1], r_isum};
            end
            MUL_D: begin
                mul_a = r_gain_d;
                mul_b = {{(MULB_W-DERR_W){r_derr[DERR_W-1]}}, r_derr};
            end
            default: begin
                mul_a = r_gain_p;
                mul_b = {{(MULB_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
        endcase
        n_prod = mul_a * mul_b;
        n_acc  = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    end

    // saturation and drive split
    always_comb begin
        bound   = $signed({{(ACC_W-OLIM_W-8){1'b0}}, r_olim, 8'b0});
        acc_sat = r_acc;
        if (acc_sat < -bound)
            acc_sat = -bound;
        if (acc_sat > bound)
            acc_sat = bound;
        base20 = $signed({2'b00, r_base, 8'b0});
        corr20 = acc_sat[DRIVE_W-1:0];
        if (r_pos > r_target) begin
            n_left  = base20 - corr20;
            n_right = base20 + corr20;
        end else if (r_pos < r_target) begin
            n_left  = base20 + corr20;
            n_right = base20 - corr20;
        end else begin
            n_left  = base20 - corr20;
            n_right = base20 - corr20;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
            r_perr <= '0;
            r_held <= '0;
        end else if (i_cmd.step_pos) begin
            r_isum <= n_isum;
            r_perr <= n_err;
            r_held <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_hits <= i_line_hits;
        if (i_cmd.step_pos) begin
            r_pos  <= n_pos;
            r_err  <= n_err;
            r_derr <= {n_err[ERR_W-1], n_err} - {r_perr[ERR_W-1], r_perr};
            r_acc  <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc  <= n_acc;
        end
        if (i_cmd.mul_en)
            r_prod <= n_prod;
        if (i_cmd.finish) begin
            r_drive_left  <= n_left;
            r_drive_right <= n_right;
            r_corr        <= acc_sat[CORR_W-1:0];
            r_out_pos     <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_drive_left    = r_drive_left;
    assign o_drive_right   = r_drive_right;
    assign o_correction    = r_corr;
    assign o_line_position = r_out_pos;

endmodule

// File: src/line_position_pid_steering_top.sv
// Line-follower steering: each sensor word (six line-detect bits) yields one
// result word with left/right drive, the saturated PID correction and the
// line position used. A word passes these steps in order: accept,
// position/error/integral update, the three gain terms one after the other
// through a single shared 16x9 multiplier, accumulate, then saturate/split
// into the output register once it no longer holds an unaccepted result.
// The output register decouples the sides, so the next word is taken while a
// result still waits; a new word is taken only after the last one is done.
// Configuration registers are to be written by the user through the plain
// write port only while no word is in work; the block does not enforce this.
module line_position_pid_steering_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lps_in_if.sink                             i_line,
    lps_out_if.source                          o_drive
);
    import lps_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_line.valid),
        .o_in_ready (i_line.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_line_hits     (i_line.line_hits),
        .o_out_valid     (o_drive.valid),
        .i_out_ready     (o_drive.ready),
        .o_drive_left    (o_drive.drive_left),
        .o_drive_right   (o_drive.drive_right),
        .o_correction    (o_drive.correction),
        .o_line_position (o_drive.line_position)
    );

endmodule

// File: src/lps_checker.sv
module lps_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [lps_pkg::DRIVE_W-1:0] i_drive_left,
    input  logic signed [lps_pkg::DRIVE_W-1:0] i_drive_right,
    input  logic signed [lps_pkg::CORR_W-1:0]  i_correction,
    input  logic [lps_pkg::POS_W-1:0]          i_line_position
);
    import lps_pkg::*;

    logic signed [DRIVE_W:0] drive_diff;
    logic signed [DRIVE_W:0] corr_x2;

    assign drive_diff = {i_drive_left[DRIVE_W-1], i_drive_left}
                      - {i_drive_right[DRIVE_W-1], i_drive_right};
    assign corr_x2    = {{(DRIVE_W-CORR_W){i_correction[CORR_W-1]}}, i_correction, 1'b0};

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while one is in work");

    // drives differ by twice the correction, or match when on target
    a_drive_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (drive_diff == '0) || (drive_diff == corr_x2)
                        || (drive_diff == -corr_x2))
        else $error("drive split inconsistent with correction");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_position <= 3'd6)
        else $error("line position out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive_left)
            && $stable(i_drive_right) && $stable(i_correction))
        else $error("stalled result word changed");

endmodule

bind line_position_pid_steering_top lps_checker u_lps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_line.valid),
    .i_in_ready      (i_line.ready),
    .i_out_valid     (o_drive.valid),
    .i_out_ready     (o_drive.ready),
    .i_drive_left    (o_drive.drive_left),
    .i_drive_right   (o_drive.drive_right),
    .i_correction    (o_drive.correction),
    .i_line_position (o_drive.line_position)
);
